/* rtl/sbvc_pkg.sv */
// Shared types, constants and character functions of the Base64/Vigenere codec.
`default_nettype none
package sbvc_pkg;

   localparam int DATA_W          = 8;
   localparam int SHIFT_W         = 8;
   localparam int KEY_LETTER_W    = 5;
   localparam int KEY_SLOTS       = 12;
   localparam int KEY_BITS        = KEY_SLOTS * KEY_LETTER_W;
   localparam int KEY_LEN_W       = 4;
   localparam int MAX_KEY_LEN_DEF = 12;
   localparam int SIX_W           = 6;
   localparam int SYM_SLOTS       = 4;
   localparam int SYM_CNT_W       = 3;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = KEY_BITS;

   localparam logic [CSR_INDEX_W-1:0] CSR_DIRECTION   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHIFT       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LETTERS = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LENGTH  = 2'd3;

   localparam logic DIR_ENCRYPT = 1'b0;
   localparam logic DIR_DECRYPT = 1'b1;

   localparam logic [DATA_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [DATA_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [DATA_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [DATA_W-1:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [DATA_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [DATA_W-1:0] CHAR_NINE    = 8'h39;
   localparam logic [DATA_W-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [DATA_W-1:0] CHAR_SLASH   = 8'h2F;
   localparam logic [DATA_W-1:0] CHAR_PAD     = 8'h3D;
   localparam int ALPHA_COUNT = 26;

   typedef struct packed {
      logic                    direction;
      logic [SHIFT_W-1:0]      shift_amount;
      logic [KEY_BITS-1:0]     key_letters;
      logic [KEY_LEN_W-1:0]    key_length;
   } cfg_type;

   typedef struct packed {
      logic             pad;
      logic [SIX_W-1:0] value;
   } sym_type;

   typedef struct packed {
      logic [DATA_W-1:0]           data;
      logic                        last;
      logic [SYM_CNT_W-1:0]        count;
      sym_type [SYM_SLOTS-1:0]     syms;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic [DATA_W-1:0] data_res;
      logic              valid_res;
      logic              run_last;
      logic              message_end;
   } result_type;

   function automatic logic is_letter(input logic [DATA_W-1:0] c);
      return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
             (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z);
   endfunction

   function automatic logic [DATA_W-1:0] b64_char(input logic [SIX_W-1:0] six);
      logic [DATA_W-1:0] c;
      if (six < 6'd26) begin
         c = CHAR_UPPER_A + DATA_W'(six);
      end else if (six < 6'd52) begin
         c = CHAR_LOWER_A + DATA_W'(six - 6'd26);
      end else if (six < 6'd62) begin
         c = CHAR_ZERO + DATA_W'(six - 6'd52);
      end else if (six == 6'd62) begin
         c = CHAR_PLUS;
      end else begin
         c = CHAR_SLASH;
      end
      return c;
   endfunction

   // bit 6 set: not in the alphabet
   function automatic logic [SIX_W:0] b64_value(input logic [DATA_W-1:0] c);
      logic [SIX_W:0] v;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         v = 7'(c - CHAR_UPPER_A);
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         v = 7'(c - CHAR_LOWER_A) + 7'd26;
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         v = 7'(c - CHAR_ZERO) + 7'd52;
      end else if (c == CHAR_PLUS) begin
         v = 7'd62;
      end else if (c == CHAR_SLASH) begin
         v = 7'd63;
      end else begin
         v = 7'd64;
      end
      return v;
   endfunction

   // c must be a letter, k in 0..25
   function automatic logic [DATA_W-1:0] vig_apply(input logic [DATA_W-1:0] c,
                                                   input logic [KEY_LETTER_W-1:0] k,
                                                   input logic enc);
      logic [DATA_W-1:0] base;
      logic [SIX_W-1:0]  v;
      logic [SIX_W-1:0]  sum;
      base = (c >= CHAR_LOWER_A) ? CHAR_LOWER_A : CHAR_UPPER_A;
      v    = SIX_W'(c - base);
      sum  = enc ? v + SIX_W'(k) : v + SIX_W'(ALPHA_COUNT) - SIX_W'(k);
      if (sum >= SIX_W'(ALPHA_COUNT)) begin
         sum = sum - SIX_W'(ALPHA_COUNT);
      end
      return base + DATA_W'(sum);
   endfunction

endpackage
`default_nettype wire

/* rtl/sbvc_if.sv */
// Valid/ready channel interfaces for request and response items.
`default_nettype none
interface sbvc_req_if;
   logic                        valid;
   logic                        ready;
   logic [sbvc_pkg::DATA_W-1:0] data;
   logic                        last;
   modport source (output valid, output data, output last, input ready);
   modport sink   (input valid, input data, input last, output ready);
endinterface

interface sbvc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sbvc_pkg::DATA_W-1:0] data_res;
   logic                        valid_res;
   logic                        run_last;
   logic                        message_end;
   modport source (output valid, output data_res, output valid_res, output run_last,
                   output message_end, input ready);
   modport sink   (input valid, input data_res, input valid_res, input run_last,
                   input message_end, output ready);
endinterface
`default_nettype wire

/* rtl/shift_base64_vigenere_codec_core.sv */
// Top level of the Base64/Vigenere codec: configuration registers and datapath wiring.
`default_nettype none
// Streaming codec. Encrypt (direction 0) takes plain bytes, adds shift_amount, emits
// Base64 text with '=' padding after the item flagged last, and Vigenere-shifts the
// letters with the key; decrypt (direction 1) reverses this and stops decoding at the
// first character outside the alphabet until the last item. Every result carries
// run_last on the final result of its item and message_end on the final result of the
// message; a decrypt item that ends a message without a byte gives a bare marker with
// valid_res low. The front end takes one item per cycle, while the queue is not full, into
// a two-entry queue; the back end emits at most one result per cycle and stalls while the
// receiver is not ready. An encrypt byte gives one to four results (four results per three
// bytes on average, two to four for the last item with padding), a decrypt character at most one.
// Writing direction clears the per-message state; write configuration only when idle.
module shift_base64_vigenere_codec_core #(
   parameter int MAX_KEY_LEN = sbvc_pkg::MAX_KEY_LEN_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   sbvc_req_if.sink                                 req_bus,
   sbvc_rsp_if.source                               rsp_bus,
   input  wire logic                                csr_we,
   input  wire logic [sbvc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [sbvc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   sbvc_pkg::cfg_type          cfg_ff;
   logic                       msg_clear;
   logic                       push, pop;
   sbvc_pkg::entry_type        push_entry, head;
   sbvc_pkg::queue_status_type q_status;

   assign msg_clear = csr_we && csr_index == sbvc_pkg::CSR_DIRECTION;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.direction    <= sbvc_pkg::DIR_ENCRYPT;
         cfg_ff.shift_amount <= '0;
         cfg_ff.key_letters  <= '0;
         cfg_ff.key_length   <= sbvc_pkg::KEY_LEN_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            sbvc_pkg::CSR_DIRECTION:   cfg_ff.direction    <= csr_wdata[0];
            sbvc_pkg::CSR_SHIFT:       cfg_ff.shift_amount <= csr_wdata[sbvc_pkg::SHIFT_W-1:0];
            sbvc_pkg::CSR_KEY_LETTERS: cfg_ff.key_letters  <= csr_wdata[sbvc_pkg::KEY_BITS-1:0];
            default:                   cfg_ff.key_length   <= csr_wdata[sbvc_pkg::KEY_LEN_W-1:0];
         endcase
      end
   end

   sbvc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .cfg        (cfg_ff),
      .msg_clear  (msg_clear),
      .q_full     (q_status.full),
      .push       (push),
      .push_entry (push_entry)
   );

   sbvc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (head),
      .status     (q_status)
   );

   sbvc_back #(
      .MAX_KEY_LEN (MAX_KEY_LEN)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .msg_clear (msg_clear),
      .q_valid   (!q_status.empty),
      .head      (head),
      .pop       (pop),
      .rsp_bus   (rsp_bus)
   );

   a_end_marks_run: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.message_end |-> rsp_bus.run_last)
      else $error("message_end without run_last");

   a_bare_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.valid_res |->
         rsp_bus.data_res == '0 && rsp_bus.run_last && rsp_bus.message_end)
      else $error("malformed bare end marker");

   a_encrypt_no_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && cfg_ff.direction == sbvc_pkg::DIR_ENCRYPT |-> rsp_bus.valid_res)
      else $error("bare marker while encrypting");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("queue popped while empty");

endmodule
`default_nettype wire

/* rtl/sbvc_front.sv */
// Front end: accepts items, does byte shift and Base64 bit packing with padding.
`default_nettype none
module sbvc_front (
   input  wire logic                clock,
   input  wire logic                reset,
   sbvc_req_if.sink                 req_bus,
   input  wire sbvc_pkg::cfg_type   cfg,
   input  wire logic                msg_clear,
   input  wire logic                q_full,
   output logic                     push,
   output sbvc_pkg::entry_type      push_entry
);

   localparam logic [1:0] PEND_0 = 2'd0;
   localparam logic [1:0] PEND_2 = 2'd1;
   localparam logic [1:0] PEND_4 = 2'd2;

   logic [1:0] pend_ff, pend_in;
   logic [3:0] held_ff, held_in;
   logic [1:0] count_ff, count_in;

   logic [sbvc_pkg::DATA_W-1:0]    s;
   logic [sbvc_pkg::SYM_CNT_W-1:0] n;
   logic [sbvc_pkg::SYM_CNT_W-1:0] n_all;
   logic [1:0]                     cnt;
   logic [1:0]                     pads;
   sbvc_pkg::sym_type [sbvc_pkg::SYM_SLOTS-1:0] syms;

   assign req_bus.ready = !q_full;
   assign push          = req_bus.valid && !q_full;

   always_comb begin
      s       = req_bus.data + cfg.shift_amount;
      syms    = '0;
      n       = 3'd1;
      pend_in = PEND_0;
      unique case (pend_ff)
         PEND_0: begin
            syms[0].value = s[7:2];
            pend_in       = PEND_2;
         end
         PEND_2: begin
            syms[0].value = {held_ff[1:0], s[7:4]};
            pend_in       = PEND_4;
         end
         default: begin
            syms[0].value = {held_ff[3:0], s[7:6]};
            syms[1].value = s[5:0];
            n             = 3'd2;
            pend_in       = PEND_0;
         end
      endcase
      if (req_bus.last && pend_in == PEND_2) begin
         syms[n[1:0]].value = {s[1:0], 4'b0000};
         n                  = n + 3'd1;
      end else if (req_bus.last && pend_in == PEND_4) begin
         syms[n[1:0]].value = {s[3:0], 2'b00};
         n                  = n + 3'd1;
      end
      cnt  = count_ff + n[1:0];
      pads = req_bus.last ? 2'(2'd0 - cnt) : 2'd0;
      for (int i = 0; i < sbvc_pkg::SYM_SLOTS; i++) begin
         if (3'(i) >= n && 3'(i) < n + {1'b0, pads}) begin
            syms[i].pad = 1'b1;
         end
      end
      n_all    = n + {1'b0, pads};
      held_in  = s[3:0];
      count_in = cnt;
      if (req_bus.last) begin
         pend_in  = PEND_0;
         count_in = 2'd0;
      end
      push_entry.data  = req_bus.data;
      push_entry.last  = req_bus.last;
      push_entry.count = n_all;
      push_entry.syms  = syms;
   end

   always_ff @(posedge clock) begin
      if (reset || msg_clear) begin
         pend_ff  <= PEND_0;
         held_ff  <= '0;
         count_ff <= '0;
      end else if (push && cfg.direction == sbvc_pkg::DIR_ENCRYPT) begin
         pend_ff  <= pend_in;
         held_ff  <= held_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/sbvc_queue.sv */
// Short queue of classified items between front and back ends.
`default_nettype none
module sbvc_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire sbvc_pkg::entry_type  push_entry,
   input  wire logic                 pop,
   output sbvc_pkg::entry_type       pop_entry,
   output sbvc_pkg::queue_status_type status
);

   localparam int PW = sbvc_pkg::QUEUE_PTR_W;
   localparam int CW = sbvc_pkg::QUEUE_CNT_W;

   sbvc_pkg::entry_type entries_ff [sbvc_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] cnt_ff, cnt_in;

   assign status.full  = cnt_ff == CW'(sbvc_pkg::QUEUE_DEPTH);
   assign status.empty = cnt_ff == '0;
   assign pop_entry    = entries_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/sbvc_back.sv */
// Back end: Vigenere stepping, Base64 decoding and the registered result stage.
`default_nettype none
module sbvc_back #(
   parameter int MAX_KEY_LEN = sbvc_pkg::MAX_KEY_LEN_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire sbvc_pkg::cfg_type   cfg,
   input  wire logic                msg_clear,
   input  wire logic                q_valid,
   input  wire sbvc_pkg::entry_type head,
   output logic                     pop,
   sbvc_rsp_if.source               rsp_bus
);

   localparam int LW = sbvc_pkg::KEY_LEN_W;
   localparam int KW = sbvc_pkg::KEY_LETTER_W;
   localparam int DW = sbvc_pkg::DATA_W;
   localparam logic [LW-1:0] MAX_LEN = LW'(MAX_KEY_LEN);

   // decoder pending bits / 2
   localparam logic [1:0] DPEND_0 = 2'd0;
   localparam logic [1:0] DPEND_2 = 2'd1;
   localparam logic [1:0] DPEND_4 = 2'd2;
   localparam logic [1:0] DPEND_6 = 2'd3;

   logic [KW-1:0] key_arr [sbvc_pkg::KEY_SLOTS];

   logic [LW-1:0] key_pos_ff, key_pos_in;
   logic [1:0]    idx_ff, idx_in;
   logic [5:0]    dbuf_ff, dbuf_in;
   logic [1:0]    dpend_ff, dpend_in;
   logic          stopped_ff, stopped_in;
   logic          out_valid_ff, out_valid_in;
   sbvc_pkg::result_type out_ff, out_in;

   logic [LW-1:0] len_eff, p_eff, p_next;
   logic [KW-1:0] k_raw, k;
   logic          slot_free, step, produce;
   logic [DW-1:0] ch, ch_out;
   logic          letter, final_sym;
   logic [sbvc_pkg::SIX_W:0] v;
   logic [11:0]   cat;
   logic [DW-1:0] dec_byte;
   sbvc_pkg::sym_type sym;

   for (genvar g = 0; g < sbvc_pkg::KEY_SLOTS; g++) begin : g_key
      assign key_arr[g] = cfg.key_letters[g*KW +: KW];
   end

   assign slot_free = !out_valid_ff || rsp_bus.ready;
   assign step      = q_valid && slot_free;

   always_comb begin
      len_eff = cfg.key_length;
      if (len_eff == '0) begin
         len_eff = LW'(1);
      end else if (len_eff > MAX_LEN) begin
         len_eff = MAX_LEN;
      end
      p_eff  = (key_pos_ff >= MAX_LEN) ? '0 : key_pos_ff;
      p_next = (p_eff + LW'(1) >= len_eff) ? '0 : p_eff + LW'(1);
      k_raw  = key_arr[p_eff];
      k      = (k_raw >= KW'(sbvc_pkg::ALPHA_COUNT)) ?
               k_raw - KW'(sbvc_pkg::ALPHA_COUNT) : k_raw;
   end

   always_comb begin
      sym        = head.syms[idx_ff];
      final_sym  = ({1'b0, idx_ff} + 3'd1) == head.count;
      key_pos_in = key_pos_ff;
      idx_in     = idx_ff;
      dbuf_in    = dbuf_ff;
      dpend_in   = dpend_ff;
      stopped_in = stopped_ff;
      produce    = 1'b0;
      out_in     = out_ff;
      pop        = 1'b0;
      cat        = {dbuf_ff, 6'b000000};
      dec_byte   = '0;
      v          = '0;
      if (cfg.direction == sbvc_pkg::DIR_ENCRYPT) begin
         ch = sym.pad ? sbvc_pkg::CHAR_PAD : sbvc_pkg::b64_char(sym.value);
      end else begin
         ch = head.data;
      end
      letter = sbvc_pkg::is_letter(ch);
      ch_out = letter ? sbvc_pkg::vig_apply(ch, k,
                                            cfg.direction == sbvc_pkg::DIR_ENCRYPT) : ch;
      if (step && cfg.direction == sbvc_pkg::DIR_ENCRYPT) begin
         produce = 1'b1;
         out_in  = '{data_res: ch_out, valid_res: 1'b1, run_last: final_sym,
                     message_end: final_sym && head.last};
         if (letter) begin
            key_pos_in = p_next;
         end
         if (final_sym) begin
            pop    = 1'b1;
            idx_in = '0;
            if (head.last) begin
               key_pos_in = '0;
            end
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end else if (step) begin
         pop = 1'b1;
         if (!stopped_ff) begin
            if (letter) begin
               key_pos_in = p_next;
            end
            v   = sbvc_pkg::b64_value(ch_out);
            cat = {dbuf_ff, v[5:0]};
            if (v[6]) begin
               stopped_in = 1'b1;
            end else begin
               dbuf_in = cat[5:0];
               unique case (dpend_ff)
                  DPEND_0: begin
                     dbuf_in  = v[5:0];
                     dpend_in = DPEND_6;
                  end
                  DPEND_2: begin
                     dec_byte = cat[7:0];
                     dpend_in = DPEND_0;
                     produce  = 1'b1;
                  end
                  DPEND_4: begin
                     dec_byte = cat[9:2];
                     dpend_in = DPEND_2;
                     produce  = 1'b1;
                  end
                  default: begin
                     dec_byte = cat[11:4];
                     dpend_in = DPEND_4;
                     produce  = 1'b1;
                  end
               endcase
            end
         end
         if (produce) begin
            out_in = '{data_res: dec_byte - cfg.shift_amount, valid_res: 1'b1,
                       run_last: 1'b1, message_end: head.last};
         end else if (head.last) begin
            produce = 1'b1;
            out_in  = '{data_res: '0, valid_res: 1'b0, run_last: 1'b1, message_end: 1'b1};
         end
         if (head.last) begin
            key_pos_in = '0;
            dbuf_in    = '0;
            dpend_in   = DPEND_0;
            stopped_in = 1'b0;
         end
      end
      out_valid_in = produce ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset || msg_clear) begin
         key_pos_ff <= '0;
         idx_ff     <= '0;
         dbuf_ff    <= '0;
         dpend_ff   <= DPEND_0;
         stopped_ff <= 1'b0;
      end else begin
         key_pos_ff <= key_pos_in;
         idx_ff     <= idx_in;
         dbuf_ff    <= dbuf_in;
         dpend_ff   <= dpend_in;
         stopped_ff <= stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         out_ff <= out_in;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.data_res    = out_ff.data_res;
   assign rsp_bus.valid_res   = out_ff.valid_res;
   assign rsp_bus.run_last    = out_ff.run_last;
   assign rsp_bus.message_end = out_ff.message_end;

endmodule
`default_nettype wire

/* test/tb_shift_base64_vigenere_codec_core.sv */
// Self-checking testbench of the shift/Base64/Vigenere codec core: directed and random messages.
`default_nettype none
import sbvc_pkg::*;

localparam string B64_SET =
   "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

// Predicts the codec output per accepted item and checks arriving results in order.
class codec_tracker;
   logic                 dir;
   logic [SHIFT_W-1:0]   shift;
   logic [KEY_BITS-1:0]  keys;
   logic [KEY_LEN_W-1:0] klen;
   logic [3:0]           kpos;
   logic [15:0]          bbuf;
   logic [3:0]           pend;
   logic                 stopped;
   logic [1:0]           ocnt;
   result_type           batch[$];
   result_type           awaited[$];
   int                   errors;
   int                   items;
   int                   messages;
   int                   results;
   int                   markers;

   function new();
      dir     = DIR_ENCRYPT;
      shift   = '0;
      keys    = '0;
      klen    = 4'd1;
      errors  = 0;
      items   = 0;
      messages = 0;
      results = 0;
      markers = 0;
      clear_message();
   endfunction

   function void clear_message();
      kpos    = '0;
      bbuf    = '0;
      pend    = '0;
      stopped = 1'b0;
      ocnt    = '0;
   endfunction

   function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_DIRECTION: begin
            dir = val[0];
            clear_message();
         end
         CSR_SHIFT: begin
            shift = val[SHIFT_W-1:0];
         end
         CSR_KEY_LETTERS: begin
            keys = val[KEY_BITS-1:0];
         end
         default: begin
            klen = val[KEY_LEN_W-1:0];
         end
      endcase
   endfunction

   function int next_key();
      int len;
      int p;
      int k;
      len = int'(klen);
      if (len == 0) len = 1;
      if (len > MAX_KEY_LEN_DEF) len = MAX_KEY_LEN_DEF;
      p = int'(kpos);
      if (p >= MAX_KEY_LEN_DEF) p = 0;
      k = int'((keys >> (KEY_LETTER_W * p)) & 60'h1F) % 26;
      kpos = (p + 1 >= len) ? 4'd0 : 4'(p + 1);
      return k;
   endfunction

   // letters move along the key; everything else passes
   function logic [7:0] shift_letter(logic [7:0] c, bit enc);
      int base;
      int k;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) base = int'(CHAR_UPPER_A);
      else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) base = int'(CHAR_LOWER_A);
      else return c;
      k = next_key();
      return 8'(base + (int'(c) - base + (enc ? k : 26 - k)) % 26);
   endfunction

   function int sextet(logic [7:0] c);
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return int'(c) - int'(CHAR_UPPER_A);
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) return int'(c) - int'(CHAR_LOWER_A) + 26;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c) - int'(CHAR_ZERO) + 52;
      if (c == CHAR_PLUS) return 62;
      if (c == CHAR_SLASH) return 63;
      return 64;
   endfunction

   function void add(logic [7:0] data, logic valid);
      result_type r;
      if (batch.size() < SYM_SLOTS) begin
         r = '0;
         r.data_res  = data;
         r.valid_res = valid;
         batch = {batch, r};
      end
   endfunction

   function void emit_symbol(int six);
      add(shift_letter(B64_SET[six & 63], 1'b1), 1'b1);
      ocnt++;
   endfunction

   function void take_item(logic [7:0] d, logic l);
      int acc;
      int bits;
      int v;
      batch.delete();
      items++;
      if (dir == DIR_ENCRYPT) begin
         acc  = (int'(bbuf) << 8) | int'(8'(d + shift));
         bits = int'(pend) + 8;
         while (bits >= 6) begin
            bits -= 6;
            emit_symbol(acc >> bits);
         end
         bbuf = 16'(acc);
         pend = 4'(bits);
         if (l) begin
            if (pend > 0) emit_symbol(int'(bbuf) << (6 - int'(pend)));
            while (ocnt != 0 && batch.size() < SYM_SLOTS) begin
               add(CHAR_PAD, 1'b1);
               ocnt++;
            end
         end
      end else begin
         if (!stopped) begin
            v = sextet(shift_letter(d, 1'b0));
            if (v > 63) begin
               stopped = 1'b1;
            end else begin
               acc  = ((int'(bbuf) << 6) | v) & 16'hFFFF;
               bits = int'(pend) + 6;
               if (bits >= 8) begin
                  bits -= 8;
                  add(8'((acc >> bits) - int'(shift)), 1'b1);
               end
               bbuf = 16'(acc);
               pend = 4'(bits);
            end
         end
         if (l && batch.size() == 0) add(8'h00, 1'b0);
      end
      if (batch.size() > 0) begin
         batch[batch.size() - 1].run_last = 1'b1;
         if (l) batch[batch.size() - 1].message_end = 1'b1;
      end
      awaited = {awaited, batch};
      if (l) begin
         messages++;
         clear_message();
      end
   endfunction

   function void check_result(result_type got);
      result_type want;
      results++;
      if (!got.valid_res) markers++;
      if (awaited.size() == 0) begin
         $display("%0t: unexpected result data_res=%h valid_res=%b run_last=%b message_end=%b",
                  $time, got.data_res, got.valid_res, got.run_last, got.message_end);
         errors++;
         return;
      end
      want = awaited.pop_front();
      if (got.data_res !== want.data_res || got.valid_res !== want.valid_res ||
          got.run_last !== want.run_last || got.message_end !== want.message_end) begin
         $display("%0t: mismatch expected data_res=%h valid_res=%b run_last=%b message_end=%b",
                  $time, want.data_res, want.valid_res, want.run_last, want.message_end);
         $display("%0t:          actual   data_res=%h valid_res=%b run_last=%b message_end=%b",
                  $time, got.data_res, got.valid_res, got.run_last, got.message_end);
         errors++;
      end
   endfunction
endclass

module tb_shift_base64_vigenere_codec_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES   = 16;
   localparam int HOLD_OFF_CYCLES = 120;
   localparam int PHASES          = 8;
   localparam int PHASE_ITEMS     = 48;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   sbvc_req_if req_bus ();
   sbvc_rsp_if rsp_bus ();

   codec_tracker book;
   int gap_max     = 0;
   int burst_left  = 0;
   bit hold_off_req = 1'b0;
   int long_holds  = 0;

   shift_base64_vigenere_codec_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin : rsp_monitor
      result_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.data_res    = rsp_bus.data_res;
         got.valid_res   = rsp_bus.valid_res;
         got.run_last    = rsp_bus.run_last;
         got.message_end = rsp_bus.message_end;
         book.check_result(got);
      end
   end

   // receiver pacing: random modes, plus one long hold-off on request
   initial begin : rsp_pacing
      int mode;
      int mode_left;
      mode      = 0;
      mode_left = 0;
      rsp_bus.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
            long_holds++;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_bus.ready <= ~rsp_bus.ready;
            endcase
         end
      end
   end

   initial begin : watchdog
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   task automatic send_item(input logic [7:0] d, input logic l);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid <= 1'b1;
      req_bus.data  <= d;
      req_bus.last  <= l;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      book.take_item(d, l);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (book.awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      book.write_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic configure(input logic d, input logic [SHIFT_W-1:0] s,
                            input logic [KEY_BITS-1:0] k, input logic [KEY_LEN_W-1:0] l);
      write_reg(CSR_DIRECTION, CSR_DATA_W'(d));
      write_reg(CSR_SHIFT, CSR_DATA_W'(s));
      write_reg(CSR_KEY_LETTERS, CSR_DATA_W'(k));
      write_reg(CSR_KEY_LENGTH, CSR_DATA_W'(l));
   endtask

   task automatic send_plain_message(output int sent);
      int len;
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) send_item(8'($urandom_range(0, 255)), i == len - 1);
      sent = len;
   endtask

   // mostly well-formed text; some noise, broken runs, padding and lone characters
   task automatic send_cipher_message(output int sent);
      int kind;
      int len;
      int pads;
      logic [7:0] c;
      kind = $urandom_range(0, 9);
      pads = $urandom_range(1, 2);
      len  = 4 * $urandom_range(1, 3);
      if (kind == 7) len = $urandom_range(1, 6);
      if (kind == 9) len = 1;
      for (int i = 0; i < len; i++) begin
         c = B64_SET[$urandom_range(0, 63)];
         if (kind == 7) c = 8'($urandom_range(0, 255));
         if (kind == 6 && i >= len - pads) c = CHAR_PAD;
         if (kind == 8 && i == len / 2) c = 8'($urandom_range(0, 255)) | 8'h80;
         send_item(c, i == len - 1);
      end
      sent = len;
   endtask

   initial begin : stimulus
      logic [KEY_BITS-1:0] ramp;
      logic [KEY_BITS-1:0] short_key;
      logic                pick_dir;
      string               text;
      int                  count;
      int                  sent;
      book = new();
      req_bus.valid <= 1'b0;
      req_bus.data  <= '0;
      req_bus.last  <= 1'b0;
      csr_we    <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      reset     <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      ramp = '0;
      for (int i = 0; i < KEY_SLOTS; i++) ramp |= KEY_BITS'(i + 1) << (KEY_LETTER_W * i);
      short_key = KEY_BITS'(3) | (KEY_BITS'(7) << 5) | (KEY_BITS'(25) << 10);

      // zero key with length 0 (acts as 1); three, one and two byte tails
      configure(DIR_ENCRYPT, 8'h00, '0, 4'd0);
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h80, 1'b1);
      send_item(8'hFF, 1'b1);
      send_item(8'h01, 1'b0);
      send_item(8'h7F, 1'b1);
      settle();

      // full shift, key entries of 31 wrap mod 26, length 15 saturates
      configure(DIR_ENCRYPT, 8'hFF, '1, 4'd15);
      send_item(8'h00, 1'b0);
      send_item(8'h55, 1'b0);
      send_item(8'hAA, 1'b0);
      send_item(8'h3C, 1'b1);
      settle();

      // key length lowered while a message is open
      configure(DIR_ENCRYPT, 8'h00, ramp, 4'd12);
      repeat (3) send_item(8'h00, 1'b0);
      settle();
      write_reg(CSR_KEY_LENGTH, CSR_DATA_W'(2));
      send_item(8'h00, 1'b1);

      // open message dropped by the direction write below
      send_item(8'h12, 1'b0);
      send_item(8'h34, 1'b0);
      settle();

      // decrypt: stop on pad, ignored tail, bare end markers
      configure(DIR_DECRYPT, 8'h55, short_key, 4'd3);
      text = "Zz09+/=";
      for (int i = 0; i < text.len(); i++) send_item(text[i], 1'b0);
      send_item(8'hFF, 1'b1);
      send_item(CHAR_PAD, 1'b1);
      send_item(CHAR_UPPER_A, 1'b1);
      settle();

      for (int phase = 0; phase < PHASES; phase++) begin
         gap_max  = (phase == 2 || phase == 5) ? 0 : $urandom_range(1, 6);
         pick_dir = (phase % 2 == 1) ? DIR_DECRYPT : DIR_ENCRYPT;
         case (phase)
            0, 3: configure(pick_dir, 8'h00, '0, 4'd1);
            1, 2: configure(pick_dir, 8'hFF, '1, 4'd12);
            default: configure(pick_dir, 8'($urandom_range(0, 255)),
                               KEY_BITS'({$urandom, $urandom}),
                               4'($urandom_range(0, 15)));
         endcase
         if (phase == 2) hold_off_req = 1'b1;
         count = 0;
         while (count < PHASE_ITEMS) begin
            if (pick_dir == DIR_ENCRYPT) send_plain_message(sent);
            else send_cipher_message(sent);
            count += sent;
         end
         settle();
      end

      $display("Ran %0d items in %0d finished messages across %0d random settings",
               book.items, book.messages, PHASES);
      $display("Checked %0d results (%0d bare end markers), %0d long receiver hold-off(s)",
               book.results, book.markers, long_holds);
      if (book.errors == 0 && book.awaited.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
